// ===== design/teq_pkg.sv =====
// Shared types and constants for the timed event queue.
// Used by teq_cell and timed_event_queue_unit; no dependencies.
package teq_pkg;

  localparam int unsigned TIME_W      = 48;
  localparam int unsigned TAG_W       = 8;
  localparam int unsigned PERIOD_W    = 20;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned MS_W        = $clog2(US_PER_MS + 1);
  localparam int unsigned PROD_W      = PERIOD_W + MS_W;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Operation codes carried in the mode field.
  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_FIRE  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // One input transaction.
  typedef struct packed {
    mode_t               mode;
    logic [TAG_W-1:0]    event_id;
    logic [TIME_W-1:0]   due_us;
    logic [PERIOD_W-1:0] period_ms;
    logic [TIME_W-1:0]   now_us;
  } in_t;

  // One output transaction.
  typedef struct packed {
    logic                fired;
    logic [TAG_W-1:0]    fired_id;
    logic [PERIOD_W-1:0] fired_period;
    logic                status;
    logic                queue_empty;
    logic [TIME_W-1:0]   time_to_next_us;
    logic                last;
  } out_t;

  // Contents of one queue slot.
  typedef struct packed {
    logic                valid;
    logic [TIME_W-1:0]   due_us;
    logic [TAG_W-1:0]    tag;
    logic [PERIOD_W-1:0] period_ms;
  } entry_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } cmd_t;

endpackage

// ===== design/teq_cell.sv =====
// One slot of the sorted event chain.
// Depends on teq_pkg; shifts toward the tail on insert and toward the head on pop.
module teq_cell (
  input  logic          clk,
  input  logic          rst,
  input  teq_pkg::cmd_t   cmd,
  input  teq_pkg::entry_t left_ent,
  input  logic          left_cond,
  input  teq_pkg::entry_t right_ent,
  output teq_pkg::entry_t ent,
  output logic          cond
);
  import teq_pkg::*;

  logic                valid;
  logic [TIME_W-1:0]   due_us;
  logic [TAG_W-1:0]    tag;
  logic [PERIOD_W-1:0] period_ms;

  assign ent = '{valid: valid, due_us: due_us, tag: tag, period_ms: period_ms};

  // The new entry belongs at or ahead of this slot; equal times go behind the new one.
  assign cond = !valid || (cmd.ent.due_us <= due_us);

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins && cond) begin
      valid <= left_cond ? left_ent.valid : 1'b1;
    end else if (cmd.pop) begin
      valid <= right_ent.valid;
    end
  end

  // Slot contents.
  always_ff @(posedge clk) begin
    if (cmd.ins && cond) begin
      if (left_cond) begin
        due_us    <= left_ent.due_us;
        tag       <= left_ent.tag;
        period_ms <= left_ent.period_ms;
      end else begin
        due_us    <= cmd.ent.due_us;
        tag       <= cmd.ent.tag;
        period_ms <= cmd.ent.period_ms;
      end
    end else if (cmd.pop) begin
      due_us    <= right_ent.due_us;
      tag       <= right_ent.tag;
      period_ms <= right_ent.period_ms;
    end
  end

endmodule

// ===== design/timed_event_queue_unit.sv =====
// Top level of the timed event queue: sequencer, output register and cell chain.
// Depends on teq_pkg and teq_cell.
//
// Keeps up to DEPTH timed events sorted by due time in a chain of cells, head
// first; an insert places the event by a compare in every cell, and a pop
// shifts the chain one slot toward the head. An add, a query or a no-op gives
// one result, which is registered in the execute state after acceptance; the
// input is taken again once the sequencer is back in idle, so the unit does not
// take a new item before it has finished the last one. A fire gives one result
// per popped event, at most 16. Each result is registered in the execute state.
// After a repeating event the new due time is formed by a multiply, a saturating
// add and a chain insert in turn before the next pop. A fire with nothing due
// gives a single result with fired low. The input is stalled while an item is
// being worked on; the output register lets the next item be taken while the
// last result still waits.
module timed_event_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  teq_pkg::in_t  in_item,
  input  logic          in_valid,
  output logic          in_stall,
  output teq_pkg::out_t out_item,
  output logic          out_valid,
  input  logic          out_stall
);
  import teq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SUM,
    S_INS
  } state_t;

  state_t                state;
  in_t                   cur;
  logic [CNT_W-1:0]      n;
  logic                  fin;
  logic [TAG_W-1:0]      pop_tag;
  logic [PERIOD_W-1:0]   pop_per;
  logic [PROD_W-1:0]     prod;
  logic [TIME_W-1:0]     sum;

  cmd_t                  cmd;
  entry_t                ents  [DEPTH];
  logic                  conds [DEPTH];

  logic                  free;
  logic                  full;
  logic                  can_pop;
  logic                  more;
  logic [TIME_W:0]       sum_wide;
  out_t                  out_next;

  // Cell chain.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent;
    logic   left_cond;
    entry_t right_ent;

    if (i == 0) begin : g_head
      assign left_ent  = '0;
      assign left_cond = 1'b0;
    end else begin : g_body
      assign left_ent  = ents[i-1];
      assign left_cond = conds[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    teq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left_ent  (left_ent),
      .left_cond (left_cond),
      .right_ent (right_ent),
      .ent       (ents[i]),
      .cond      (conds[i])
    );
  end

  assign free     = !out_valid || !out_stall;
  assign full     = ents[DEPTH-1].valid;
  assign in_stall = (state != S_IDLE);

  // Head is due and the per-transaction pop limit is not yet reached.
  assign can_pop = ents[0].valid && (ents[0].due_us <= cur.now_us) &&
                   (n < CNT_W'(MAX_RESULTS));

  // Whether another pop follows this one. A reinserted event lands at or before
  // now only when its time saturates and now is already at the top of the range.
  assign more = (n != CNT_W'(MAX_RESULTS - 1)) &&
                ((ents[1].valid && (ents[1].due_us <= cur.now_us)) ||
                 ((ents[0].period_ms != '0) && (cur.now_us == TIME_MAX)));

  assign sum_wide = {1'b0, cur.now_us} + (TIME_W+1)'(prod);

  // Command to the chain.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_EXEC: begin
        if (free && (cur.mode == MODE_ADD) && !full) begin
          cmd.ins           = 1'b1;
          cmd.ent.valid     = 1'b1;
          cmd.ent.due_us    = cur.due_us;
          cmd.ent.tag       = cur.event_id;
          cmd.ent.period_ms = cur.period_ms;
        end else if (free && (cur.mode == MODE_FIRE) && can_pop) begin
          cmd.pop = 1'b1;
        end
      end
      S_INS: begin
        cmd.ins           = 1'b1;
        cmd.ent.valid     = 1'b1;
        cmd.ent.due_us    = sum;
        cmd.ent.tag       = pop_tag;
        cmd.ent.period_ms = pop_per;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Result of the current step.
  always_comb begin
    out_next      = '0;
    out_next.last = 1'b1;
    unique case (cur.mode)
      MODE_ADD: begin
        out_next.status = full;
      end
      MODE_FIRE: begin
        if (can_pop) begin
          out_next.fired        = 1'b1;
          out_next.fired_id     = ents[0].tag;
          out_next.fired_period = ents[0].period_ms;
          out_next.last         = !more;
        end
      end
      MODE_QUERY: begin
        if (!ents[0].valid) begin
          out_next.queue_empty = 1'b1;
        end else if (ents[0].due_us > cur.now_us) begin
          out_next.time_to_next_us = ents[0].due_us - cur.now_us;
        end
      end
      default: begin
        out_next.status = 1'b0;
      end
    endcase
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EXEC) && free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      fin       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur   <= in_item;
            n     <= '0;
            fin   <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (free) begin
            out_item <= out_next;
            if ((cur.mode == MODE_FIRE) && can_pop) begin
              n       <= n + CNT_W'(1);
              fin     <= !more;
              pop_tag <= ents[0].tag;
              pop_per <= ents[0].period_ms;
              prod    <= PROD_W'(ents[0].period_ms) * PROD_W'(US_PER_MS);
              if (ents[0].period_ms != '0) begin
                state <= S_SUM;
              end else if (more) begin
                state <= S_EXEC;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SUM: begin
          // Saturate the repeat time at the top of the time range.
          sum   <= sum_wide[TIME_W] ? TIME_MAX : sum_wide[TIME_W-1:0];
          state <= S_INS;
        end
        S_INS: begin
          state <= fin ? S_IDLE : S_EXEC;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
